/* hdl/ptlm_pkg.sv */
// ----------------------------------------------------------------------------
// ptlm_pkg: shared types and constants for the paging MMU
// Word layouts, command and status codes, controller states and ops.
// ----------------------------------------------------------------------------
package ptlm_pkg;

   localparam int PROCS_DEF  = 8;
   localparam int PAGES_DEF  = 64;
   localparam int FRAMES_DEF = 64;

   localparam int CMD_W   = 2;
   localparam int PROC_W  = 3;
   localparam int PAGE_W  = 7;
   localparam int STAT_W  = 3;
   localparam int FRM_W   = 6;
   localparam int VPG_W   = 6;
   localparam int FCNT_W  = 16;
   localparam int NF_W    = 7;
   localparam int LU_W    = 32;
   localparam int WIDE_W  = 12;   // compare width, holds any count in range

   localparam logic [NF_W-1:0]   NF_RESET  = NF_W'(64);
   localparam logic [FCNT_W-1:0] FCNT_MAX  = '1;

   localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LIMIT  = 2'd2;

   localparam logic [STAT_W-1:0] RSP_HIT      = 3'd0;
   localparam logic [STAT_W-1:0] RSP_LOADED   = 3'd1;
   localparam logic [STAT_W-1:0] RSP_NO_FRAME = 3'd2;
   localparam logic [STAT_W-1:0] RSP_INVALID  = 3'd3;
   localparam logic [STAT_W-1:0] RSP_FINISHED = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [PROC_W-1:0] process;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [FRM_W-1:0]  frame;
      logic              evicted;
      logic [VPG_W-1:0]  victim_page;
      logic [FCNT_W-1:0] fault_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_DECIDE,
      ST_HIT,
      ST_FREE,
      ST_LRU,
      ST_LRU_FIN,
      ST_REL,
      ST_REL_FIN,
      ST_RESP
   } ptlm_state_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LATCH,
      OP_SETLIM,
      OP_DECIDE,
      OP_HIT,
      OP_FREESTEP,
      OP_COMMIT_FREE,
      OP_LRUSTEP,
      OP_COMMIT_LRU,
      OP_RELSTEP,
      OP_COMMIT_REL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic drop;
      logic is_limit;
      logic is_finish;
      logic over;
      logic hit;
      logic free_hit;
      logic free_last;
      logic scan_done;
   } dp_stat_type;

endpackage

/* hdl/page_table_lru_mmu.sv */
// ----------------------------------------------------------------------------
// page_table_lru_mmu: demand-paging MMU with per-process LRU replacement
// Sequencer plus datapath; page tables held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Command word on req_word is taken at a clock edge with start high and
//    busy low. busy then stays high until the command is complete.
//  - Access and finish commands give one response word on rsp_word, valid for
//    exactly one cycle with rsp_valid. Set-limit, unused commands and
//    out-of-range processes give none. The receiver cannot stall.
//  - csr_wdata sets the number of usable frames; csr_ready is always high,
//    write only while busy is low.
//  - Response time depends on the path: a hit; a fault into a free frame,
//    after a search of the usable frames; a fault through the LRU scan,
//    after that search and a page scan; a release (finish, invalid
//    ref), after a page scan. The scans do one page-table RAM read per cycle.
//  - One command at a time; busy drops the cycle after rsp_valid, and only
//    then can the next word be taken. Set-limit and ignored words hold busy
//    for one cycle.
//  - Reset (synchronous) empties every row, frees all frames, clears limits,
//    fault counters and the use clock; no sweep.
// ----------------------------------------------------------------------------
module page_table_lru_mmu
   import ptlm_pkg::*;
#(
   parameter int PROCS  = PROCS_DEF,
   parameter int PAGES  = PAGES_DEF,
   parameter int FRAMES = FRAMES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_type         req_word,
   output logic            rsp_valid,
   output rsp_type         rsp_word,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [NF_W-1:0] csr_wdata
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   ptlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (dp_stat),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ptlm_dp #(.PROCS(PROCS), .PAGES(PAGES), .FRAMES(FRAMES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .stat      (dp_stat),
      .req_word  (req_word),
      .csr_valid (csr_valid & csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_word  (rsp_word)
   );

   // a response only ever comes out of a command in progress
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response while idle");

   // one word per command
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response repeated");

   // busy only rises from an accepted command
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy without start");

   // evictions only accompany a loaded fault
   a_evict_loaded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.evicted) |-> (rsp_word.status == RSP_LOADED))
      else $error("eviction on wrong status");

endmodule

/* hdl/ptlm_ram.sv */
// ----------------------------------------------------------------------------
// ptlm_ram: generic single-write, single-read RAM
// One write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

/* hdl/ptlm_ctrl.sv */
// ----------------------------------------------------------------------------
// ptlm_ctrl: sequencer for the paging MMU
// Walks each command through lookup, frame search, LRU or release scans.
// ----------------------------------------------------------------------------
module ptlm_ctrl
   import ptlm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output dp_cmd_type  dp_cmd,
   output logic        busy,
   output logic        rsp_valid
);

   ptlm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_ROW;
         end
         ST_ROW: begin
            if (stat.drop || stat.is_limit) state_in = ST_IDLE;
            else state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.is_finish || stat.over) state_in = ST_REL;
            else if (stat.hit) state_in = ST_HIT;
            else state_in = ST_FREE;
         end
         ST_HIT:     state_in = ST_RESP;
         ST_FREE: begin
            if (stat.free_hit) state_in = ST_RESP;
            else if (stat.free_last) state_in = ST_LRU;
         end
         ST_LRU: begin
            if (stat.scan_done) state_in = ST_LRU_FIN;
         end
         ST_LRU_FIN: state_in = ST_RESP;
         ST_REL: begin
            if (stat.scan_done) state_in = ST_REL_FIN;
         end
         ST_REL_FIN: state_in = ST_RESP;
         ST_RESP:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd.op = OP_IDLE;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) dp_cmd.op = OP_LATCH;
         end
         ST_ROW: begin
            if (!stat.drop && stat.is_limit) dp_cmd.op = OP_SETLIM;
         end
         ST_DECIDE:  dp_cmd.op = OP_DECIDE;
         ST_HIT:     dp_cmd.op = OP_HIT;
         ST_FREE: begin
            if (stat.free_hit) dp_cmd.op = OP_COMMIT_FREE;
            else dp_cmd.op = OP_FREESTEP;
         end
         ST_LRU:     dp_cmd.op = OP_LRUSTEP;
         ST_LRU_FIN: dp_cmd.op = OP_COMMIT_LRU;
         ST_REL:     dp_cmd.op = OP_RELSTEP;
         ST_REL_FIN: dp_cmd.op = OP_COMMIT_REL;
         ST_RESP:    rsp_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

endmodule

/* hdl/ptlm_dp.sv */
// ----------------------------------------------------------------------------
// ptlm_dp: datapath of the paging MMU
// Page tables in RAM, free frame map, limits, fault counters, use clock.
// ----------------------------------------------------------------------------
module ptlm_dp
   import ptlm_pkg::*;
#(
   parameter int PROCS  = PROCS_DEF,
   parameter int PAGES  = PAGES_DEF,
   parameter int FRAMES = FRAMES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  dp_cmd_type      dp_cmd,
   output dp_stat_type     stat,
   input  req_type         req_word,
   input  logic            csr_valid,
   input  logic [NF_W-1:0] csr_wdata,
   output rsp_type         rsp_word
);

   localparam int PROC_IW  = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int PAGE_IW  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int FRAME_IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ENTRIES  = PROCS * PAGES;
   localparam int ENT_AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENT_W    = FRAME_IW + LU_W;
   localparam int MAXN     = (PAGES > FRAMES) ? PAGES : FRAMES;
   localparam int CNT_W    = $clog2(MAXN + 1);

   // registers
   req_type             req_ff, req_in;
   logic [NF_W-1:0]     nf_ff, nf_in;
   logic [LU_W-1:0]     clock_ff, clock_in;
   logic [PAGE_W-1:0]   limit_ff [PROCS];
   logic [PAGE_W-1:0]   limit_in [PROCS];
   logic [FCNT_W-1:0]   faults_ff [PROCS];
   logic [FCNT_W-1:0]   faults_in [PROCS];
   logic [PROCS-1:0]    rowv_ff, rowv_in;
   logic [FRAMES-1:0]   free_ff, free_in;
   logic [PAGES-1:0]    row_ff, row_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic [PAGE_IW-1:0]  pidx_ff, pidx_in;
   logic                found_ff, found_in;
   logic [LU_W-1:0]     best_ff, best_in;
   logic [PAGE_IW-1:0]  victim_ff, victim_in;
   logic [FRAME_IW-1:0] vframe_ff, vframe_in;
   rsp_type             rsp_ff, rsp_in;

   // memories
   logic                row_we;
   logic [PAGES-1:0]    row_wdata, row_q, row_now;
   logic                ent_we;
   logic [ENT_W-1:0]    ent_wdata, ent_q;
   logic [ENT_AW-1:0]   ent_base, ent_addr_page, ent_addr_scan, ent_raddr;

   logic [PROC_IW-1:0]  pix;
   logic [PAGE_IW-1:0]  pg_ix, cnt_ix;
   logic [FRAME_IW-1:0] fr_ix, ent_frame;
   logic [LU_W-1:0]     ent_lu, age;
   logic [WIDE_W-1:0]   lim_w, lim_eff, nf_eff, cnt_w;
   logic                scan_in_range;
   logic [FCNT_W-1:0]   fault_now, fault_next;
   logic [PAGES-1:0]    pbit, vbit;

   assign pix       = PROC_IW'(req_ff.process);
   assign pg_ix     = PAGE_IW'(req_ff.page);
   assign cnt_ix    = PAGE_IW'(cnt_ff);
   assign fr_ix     = FRAME_IW'(cnt_ff);
   assign cnt_w     = WIDE_W'(cnt_ff);
   assign ent_frame = ent_q[ENT_W-1:LU_W];
   assign ent_lu    = ent_q[LU_W-1:0];
   assign age       = clock_ff - ent_lu;

   assign lim_w   = WIDE_W'(limit_ff[pix]);
   assign lim_eff = (lim_w > WIDE_W'(PAGES)) ? WIDE_W'(PAGES) : lim_w;
   assign nf_eff  = (WIDE_W'(nf_ff) > WIDE_W'(FRAMES)) ? WIDE_W'(FRAMES)
                                                      : WIDE_W'(nf_ff);
   assign row_now = rowv_ff[pix] ? row_q : '0;
   assign scan_in_range = cnt_w < WIDE_W'(PAGES);

   assign fault_now  = faults_ff[pix];
   assign fault_next = (fault_now == FCNT_MAX) ? fault_now : fault_now + 1'b1;

   assign ent_base      = ENT_AW'(pix) * ENT_AW'(PAGES);
   assign ent_addr_page = ent_base + ENT_AW'(pg_ix);
   assign ent_addr_scan = ent_base + ENT_AW'(cnt_ix);
   assign ent_raddr     = (dp_cmd.op == OP_DECIDE) ? ent_addr_page : ent_addr_scan;

   always_comb begin
      pbit        = '0;
      pbit[pg_ix] = 1'b1;
      vbit            = '0;
      vbit[victim_ff] = 1'b1;
   end

   // status to the sequencer
   always_comb begin
      stat.drop      = (WIDE_W'(req_ff.process) >= WIDE_W'(PROCS))
                       || (req_ff.cmd != CMD_ACCESS && req_ff.cmd != CMD_FINISH
                           && req_ff.cmd != CMD_LIMIT);
      stat.is_limit  = (req_ff.cmd == CMD_LIMIT);
      stat.is_finish = (req_ff.cmd == CMD_FINISH);
      stat.over      = WIDE_W'(req_ff.page) >= lim_eff;
      stat.hit       = row_now[pg_ix];
      stat.free_hit  = (cnt_w < nf_eff) && free_ff[fr_ix];
      stat.free_last = (cnt_w + 1'b1) >= nf_eff;
      stat.scan_done = !scan_in_range;
   end

   always_comb begin
      req_in    = req_ff;
      nf_in     = csr_valid ? csr_wdata : nf_ff;
      clock_in  = clock_ff;
      limit_in  = limit_ff;
      faults_in = faults_ff;
      rowv_in   = rowv_ff;
      free_in   = free_ff;
      row_in    = row_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      pidx_in   = pidx_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      victim_in = victim_ff;
      vframe_in = vframe_ff;
      rsp_in    = rsp_ff;
      row_we    = 1'b0;
      row_wdata = row_ff;
      ent_we    = 1'b0;
      ent_wdata = {ent_frame, clock_ff};

      case (dp_cmd.op)
         OP_LATCH:  req_in = req_word;
         OP_SETLIM: limit_in[pix] = req_ff.page;
         OP_DECIDE: begin
            row_in   = row_now;
            cnt_in   = '0;
            found_in = 1'b0;
         end
         OP_HIT: begin
            ent_we   = 1'b1;
            rsp_in   = '{RSP_HIT, FRM_W'(ent_frame), 1'b0, '0, fault_now};
            clock_in = clock_ff + 1'b1;
         end
         OP_FREESTEP: begin
            cnt_in = stat.free_last ? '0 : cnt_ff + 1'b1;
         end
         OP_COMMIT_FREE: begin
            ent_we         = 1'b1;
            ent_wdata      = {fr_ix, clock_ff};
            row_we         = 1'b1;
            row_wdata      = row_ff | pbit;
            rowv_in[pix]   = 1'b1;
            free_in[fr_ix] = 1'b0;
            faults_in[pix] = fault_next;
            rsp_in         = '{RSP_LOADED, FRM_W'(fr_ix), 1'b0, '0, fault_next};
            clock_in       = clock_ff + 1'b1;
         end
         OP_LRUSTEP, OP_RELSTEP: begin
            if (scan_in_range) cnt_in = cnt_ff + 1'b1;
            pend_in = scan_in_range && row_ff[cnt_ix];
            pidx_in = cnt_ix;
            if (pend_ff) begin
               if (dp_cmd.op == OP_LRUSTEP) begin
                  // strict compare keeps the lowest page on equal ages
                  if (!found_ff || age > best_ff) begin
                     found_in  = 1'b1;
                     best_in   = age;
                     victim_in = pidx_ff;
                     vframe_in = ent_frame;
                  end
               end else if (WIDE_W'(ent_frame) < WIDE_W'(FRAMES)) begin
                  free_in[ent_frame] = 1'b1;
               end
            end
         end
         OP_COMMIT_LRU: begin
            faults_in[pix] = fault_next;
            if (found_ff) begin
               ent_we       = 1'b1;
               ent_wdata    = {vframe_ff, clock_ff};
               row_we       = 1'b1;
               row_wdata    = (row_ff & ~vbit) | pbit;
               rowv_in[pix] = 1'b1;
               rsp_in       = '{RSP_LOADED, FRM_W'(vframe_ff), 1'b1,
                                VPG_W'(victim_ff), fault_next};
            end else begin
               rsp_in = '{RSP_NO_FRAME, '0, 1'b0, '0, fault_next};
            end
            clock_in = clock_ff + 1'b1;
         end
         OP_COMMIT_REL: begin
            row_we       = 1'b1;
            row_wdata    = '0;
            rowv_in[pix] = 1'b1;
            rsp_in       = '{(stat.is_finish ? RSP_FINISHED : RSP_INVALID),
                             '0, 1'b0, '0, fault_now};
            clock_in     = clock_ff + 1'b1;
         end
         default: req_in = req_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff     <= NF_RESET;
         clock_ff  <= '0;
         rowv_ff   <= '0;
         free_ff   <= '1;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         limit_ff  <= '{default: '0};
         faults_ff <= '{default: '0};
      end else begin
         nf_ff     <= nf_in;
         clock_ff  <= clock_in;
         rowv_ff   <= rowv_in;
         free_ff   <= free_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         limit_ff  <= limit_in;
         faults_ff <= faults_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      row_ff    <= row_in;
      cnt_ff    <= cnt_in;
      pidx_ff   <= pidx_in;
      best_ff   <= best_in;
      victim_ff <= victim_in;
      vframe_ff <= vframe_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_word = rsp_ff;

   ptlm_ram #(.WIDTH(PAGES), .DEPTH(PROCS)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (pix),
      .wr_data (row_wdata),
      .rd_addr (pix),
      .rd_data (row_q)
   );

   ptlm_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_addr_page),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_q)
   );

endmodule

/* test/tb_page_table_lru_mmu.sv */
// ----------------------------------------------------------------------------
// tb_page_table_lru_mmu: self-checking bench for the paging MMU
// Drives command words with random gaps, keeps its own page-table model and
// checks each response word in order against it. The frame count is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_page_table_lru_mmu;
   import ptlm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC  = 8;
   localparam int NPAGE  = 64;
   localparam int NFRAME = 64;
   localparam int STALL_LIMIT = 20000;
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // scoreboard: page-table model plus queue of expected response words
   class mmu_scoreboard;
      bit          valid_tbl [NPROC*NPAGE];
      bit [5:0]    frame_tbl [NPROC*NPAGE];
      bit [31:0]   stamp_tbl [NPROC*NPAGE];
      bit          free_tbl  [NFRAME];
      bit [6:0]    limit_tbl [NPROC];
      bit [15:0]   fault_tbl [NPROC];
      bit [31:0]   use_clk;
      bit [6:0]    nframes;
      rsp_type     pending[$];
      int          mismatches;

      function void clear();
         foreach (valid_tbl[i]) begin
            valid_tbl[i] = 0;
            frame_tbl[i] = 0;
            stamp_tbl[i] = 0;
         end
         foreach (free_tbl[i]) free_tbl[i] = 1;
         foreach (limit_tbl[i]) begin
            limit_tbl[i] = 0;
            fault_tbl[i] = 0;
         end
         use_clk = 0;
         nframes = NF_RESET;
         mismatches = 0;
      endfunction

      function void release_proc(int p);
         for (int j = 0; j < NPAGE; j++)
            if (valid_tbl[p*NPAGE+j]) begin
               free_tbl[frame_tbl[p*NPAGE+j]] = 1;
               valid_tbl[p*NPAGE+j] = 0;
            end
      endfunction

      // note an accepted command word, queue its response if it has one
      function void note_command(req_type r);
         rsp_type w;
         int p, e, lim, nf, victim;
         bit found, done;
         bit [31:0] best, age;
         p = r.process;
         w = '0;
         if (r.cmd == CMD_LIMIT) begin
            limit_tbl[p] = r.page;
            return;
         end
         if (r.cmd != CMD_ACCESS && r.cmd != CMD_FINISH) return;
         if (r.cmd == CMD_FINISH) begin
            release_proc(p);
            w.status = RSP_FINISHED;
         end else begin
            lim = (limit_tbl[p] > NPAGE) ? NPAGE : limit_tbl[p];
            e = p*NPAGE + r.page;
            if (r.page >= lim) begin
               release_proc(p);
               w.status = RSP_INVALID;
            end else if (valid_tbl[e]) begin
               stamp_tbl[e] = use_clk;
               w.status = RSP_HIT;
               w.frame = frame_tbl[e];
            end else begin
               if (fault_tbl[p] != FCNT_MAX) fault_tbl[p]++;
               nf = (nframes > NFRAME) ? NFRAME : nframes;
               done = 0;
               for (int i = 0; i < nf && !done; i++)
                  if (free_tbl[i]) begin
                     free_tbl[i] = 0;
                     frame_tbl[e] = FRM_W'(i);
                     valid_tbl[e] = 1;
                     stamp_tbl[e] = use_clk;
                     w.status = RSP_LOADED;
                     w.frame = FRM_W'(i);
                     done = 1;
                  end
               if (!done) begin
                  found = 0;
                  best = 0;
                  victim = 0;
                  for (int j = 0; j < NPAGE; j++)
                     if (valid_tbl[p*NPAGE+j]) begin
                        age = use_clk - stamp_tbl[p*NPAGE+j];
                        if (!found || age > best) begin
                           found = 1;
                           best = age;
                           victim = j;
                        end
                     end
                  if (found) begin
                     frame_tbl[e] = frame_tbl[p*NPAGE+victim];
                     valid_tbl[p*NPAGE+victim] = 0;
                     valid_tbl[e] = 1;
                     stamp_tbl[e] = use_clk;
                     w.status = RSP_LOADED;
                     w.frame = frame_tbl[e];
                     w.evicted = 1;
                     w.victim_page = VPG_W'(victim);
                  end else
                     w.status = RSP_NO_FRAME;
               end
            end
         end
         w.fault_count = fault_tbl[p];
         use_clk++;
         pending.push_back(w);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.frame !== want.frame ||
             got.evicted !== want.evicted || got.victim_page !== want.victim_page ||
             got.fault_count !== want.fault_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch: expected st=%0d fr=%0d ev=%0d vp=%0d fc=%0d",
                        want.status, want.frame, want.evicted, want.victim_page,
                        want.fault_count);
               $display("                   actual   st=%0d fr=%0d ev=%0d vp=%0d fc=%0d",
                        got.status, got.frame, got.evicted, got.victim_page,
                        got.fault_count);
            end
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_type         req_word;
   logic            rsp_valid;
   rsp_type         rsp_word;
   logic            csr_valid;
   logic            csr_ready;
   logic [NF_W-1:0] csr_wdata;

   mmu_scoreboard table_model;
   int            idle_cycles = 0;
   bit            gaps_on;

   page_table_lru_mmu u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // response monitor; the receiver never stalls, so every strobe is a word
   always @(posedge clock) begin
      if (!reset && rsp_valid) table_model.check_response(rsp_word);
   end

   // watchdog: counts cycles in which no word is moved on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // one command word; start held until the handshake completes and left
   // high afterwards, the next call or an idle step takes it down
   task automatic send_command(input logic [1:0] c, input int p, input int pg);
      req_type r;
      r.cmd = c;
      r.process = PROC_W'(p);
      r.page = PAGE_W'(pg);
      if (gaps_on && $urandom_range(99) < 16) begin
         start <= 1'b0;
         req_word <= req_type'($bits(req_type)'($urandom));
         @(posedge clock);
         while (gaps_on && $urandom_range(99) < 16) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= r;
      do @(posedge clock); while (busy);
      table_model.note_command(r);
   endtask

   // wait for the block to drain, then write the frame count
   task automatic write_frames(input int n);
      start <= 1'b0;
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (NFRAME + NPAGE + 12) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= NF_W'(n);
      do @(posedge clock); while (!csr_ready);
      table_model.nframes = NF_W'(n);
      csr_valid <= 1'b0;
   endtask

   // random phase; mostly in-range accesses on a small working set
   task automatic random_phase(input int count);
      int p, r;
      for (int k = 0; k < count; k++) begin
         gaps_on = !(k > count/3 && k < count/2);
         p = $urandom_range(7);
         r = $urandom_range(99);
         if (r < 70)
            send_command(CMD_ACCESS, p, $urandom_range(0, (r < 60) ? 20 : 127));
         else if (r < 78)
            send_command(CMD_LIMIT, p, $urandom_range(0, 99) < 85 ?
                         $urandom_range(8, 30) : $urandom_range(0, 127));
         else if (r < 83) send_command(CMD_FINISH, p, $urandom_range(127));
         else if (r < 86) send_command(CMD_SPARE, p, $urandom_range(127));
         else send_command(CMD_ACCESS, p, $urandom_range(0, 127));
      end
   endtask

   initial begin
      table_model = new();
      table_model.clear();
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      gaps_on = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: limits, free load, hit, invalid, finish, unused command
      send_command(CMD_ACCESS, 0, 0);          // limit zero: invalid
      send_command(CMD_LIMIT, 0, 127);         // above page count, clipped
      send_command(CMD_LIMIT, 7, 2);
      send_command(CMD_ACCESS, 0, 63);
      send_command(CMD_ACCESS, 0, 63);         // hit
      send_command(CMD_ACCESS, 0, 64);         // past clipped limit
      send_command(CMD_ACCESS, 7, 1);
      send_command(CMD_ACCESS, 7, 127);
      send_command(CMD_SPARE, 7, 85);          // ignored
      send_command(CMD_FINISH, 7, 42);
      write_frames(2);                         // tiny pool: LRU evictions
      send_command(CMD_ACCESS, 0, 1);
      send_command(CMD_ACCESS, 0, 2);
      send_command(CMD_ACCESS, 0, 63);
      send_command(CMD_ACCESS, 0, 5);
      send_command(CMD_LIMIT, 3, 5);
      send_command(CMD_ACCESS, 3, 4);          // no frame and no victim
      send_command(CMD_FINISH, 0, 0);
      send_command(CMD_ACCESS, 3, 4);
      write_frames(1);
      random_phase(300);
      write_frames(0);                         // no frame is ever free
      random_phase(150);
      write_frames(127);                       // above frame count, clipped
      random_phase(400);
      write_frames(64);
      random_phase(400);
      write_frames(12);
      random_phase(500);

      start <= 1'b0;
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (NFRAME + NPAGE + 12) @(posedge clock);
      if (table_model.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* sim.f */
hdl/ptlm_pkg.sv
hdl/ptlm_ram.sv
hdl/ptlm_ctrl.sv
hdl/ptlm_dp.sv
hdl/page_table_lru_mmu.sv
test/tb_page_table_lru_mmu.sv
